@@ hw/rtl/gemm_tile_relu_unit_defines.svh @@
// Assertion macros used by the top level to check the tile's behavior.
`ifndef GEMM_TILE_RELU_UNIT_DEFINES_SVH
`define GEMM_TILE_RELU_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GTR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/gtr_pkg.sv @@
// Package with the shared types and constants of the matrix-multiply tile.
`timescale 1ns / 1ps

package gtr_pkg;

   localparam int RowLanesDefault   = 4;
   localparam int ColLanesDefault   = 4;
   localparam int WeightRowsDefault = 64;
   localparam int ElemBitsDefault   = 16;

   localparam int MaxLanes    = 4;
   localparam int FieldBits   = 16;
   localparam int RowBits     = 6;
   localparam int AccBits     = 32;
   localparam int ResultBits  = 31;
   localparam int OutRowBits  = 2;
   localparam int DepthBits   = 7;
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;

   localparam logic [DepthBits-1:0] AccDepthReset = 7'd64;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_ACT    = 1'b1;

   localparam logic CSR_ACC_DEPTH = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_ACC  = 3'b100
   } gtr_state_type;

   typedef struct packed {
      logic prod_en;
      logic acc_en;
      logic acc_load;
   } gtr_lane_ctl_type;

endpackage

@@ hw/rtl/gtr_lane.sv @@
// One row lane: multiplies its activation element by the weight row and accumulates.
`timescale 1ns / 1ps

module gtr_lane #(
   parameter int COL_LANES = gtr_pkg::ColLanesDefault,
   parameter int ELEM_BITS = gtr_pkg::ElemBitsDefault
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  gtr_pkg::gtr_lane_ctl_type                    ctl,
   input  logic [ELEM_BITS-1:0]                         act,
   input  logic [COL_LANES-1:0][ELEM_BITS-1:0]          wrow,
   output logic [COL_LANES-1:0][gtr_pkg::AccBits-1:0]   acc
);

   logic [COL_LANES-1:0][gtr_pkg::AccBits-1:0] prod_ff;
   logic [COL_LANES-1:0][gtr_pkg::AccBits-1:0] prod_in;
   logic [COL_LANES-1:0][gtr_pkg::AccBits-1:0] acc_ff;
   logic [COL_LANES-1:0][gtr_pkg::AccBits-1:0] acc_in;

   for (genvar j = 0; j < COL_LANES; j++) begin : g_col
      logic signed [2*ELEM_BITS-1:0] prod_full;

      assign prod_full  = $signed(act) * $signed(wrow[j]);
      assign prod_in[j] = gtr_pkg::AccBits'(prod_full);
      assign acc_in[j]  = ctl.acc_load ? prod_ff[j] : acc_ff[j] + prod_ff[j];
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ hw/rtl/gtr_drain.sv @@
// Merging stage that sends the accumulator rows out one per cycle with ReLU applied.
`timescale 1ns / 1ps

module gtr_drain #(
   parameter int ROW_LANES = gtr_pkg::RowLanesDefault,
   parameter int COL_LANES = gtr_pkg::ColLanesDefault
) (
   input  logic                                                       clock,
   input  logic                                                       reset,
   input  logic                                                       go,
   input  logic [ROW_LANES-1:0][COL_LANES-1:0][gtr_pkg::AccBits-1:0]  accs,
   output logic                                                       busy,
   output logic                                                       rsp_valid,
   output logic [gtr_pkg::OutRowBits-1:0]                             rsp_out_row,
   output logic [gtr_pkg::MaxLanes-1:0][gtr_pkg::ResultBits-1:0]      rsp_cols,
   output logic                                                       rsp_last
);

   localparam int RowCntBits = (ROW_LANES > 1) ? $clog2(ROW_LANES) : 1;

   logic                                                  active_ff;
   logic                                                  active_in;
   logic [RowCntBits-1:0]                                 row_ff;
   logic [RowCntBits-1:0]                                 row_in;
   logic                                                  at_last;
   logic                                                  valid_ff;
   logic [gtr_pkg::OutRowBits-1:0]                        out_row_ff;
   logic [gtr_pkg::MaxLanes-1:0][gtr_pkg::ResultBits-1:0] cols_ff;
   logic [gtr_pkg::MaxLanes-1:0][gtr_pkg::ResultBits-1:0] cols_in;
   logic                                                  last_ff;

   assign at_last = (row_ff == RowCntBits'(ROW_LANES - 1));

   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      if (go) begin
         active_in = 1'b1;
         row_in    = '0;
      end else if (active_ff) begin
         row_in = row_ff + 1'b1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end
   end

   for (genvar j = 0; j < gtr_pkg::MaxLanes; j++) begin : g_relu
      if (j < COL_LANES) begin : g_used
         assign cols_in[j] = accs[row_ff][j][gtr_pkg::AccBits-1] ?
                             '0 : accs[row_ff][j][gtr_pkg::ResultBits-1:0];
      end else begin : g_unused
         assign cols_in[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
         valid_ff  <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (active_ff) begin
         out_row_ff <= gtr_pkg::OutRowBits'(row_ff);
         cols_ff    <= cols_in;
         last_ff    <= at_last;
      end
   end

   assign busy        = active_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_cols    = cols_ff;
   assign rsp_last    = last_ff;

endmodule

@@ hw/rtl/gemm_tile_relu_unit.sv @@
// Top level of the output-stationary matrix-multiply tile with ReLU.
//
//   port group   direction  handshake                     contents
//   req_*        in         start high while busy low     kind, row, e0..e3
//   rsp_*        out        rsp_valid for one cycle       out_row, c0..c3, last
//   p*           in/out     APB write, pready tied high   acc_depth at address 0
//
// A weight item is written to memory; an activation item passes through the
// registered read of the weight memory, the registered multiplier stage of the
// lanes and the accumulate. The item that completes a tile then sends ROW_LANES
// rows, one per cycle, and busy stays high until the last row is in the output
// register. Reset clears the step count, the accumulators and acc_depth (to 64);
// the weight memory holds no defined value until written. Results cannot be stalled.
`timescale 1ns / 1ps

`include "gemm_tile_relu_unit_defines.svh"

module gemm_tile_relu_unit #(
   parameter int ROW_LANES   = gtr_pkg::RowLanesDefault,
   parameter int COL_LANES   = gtr_pkg::ColLanesDefault,
   parameter int WEIGHT_ROWS = gtr_pkg::WeightRowsDefault,
   parameter int ELEM_BITS   = gtr_pkg::ElemBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [gtr_pkg::RowBits-1:0]         req_row,
   input  logic signed [gtr_pkg::FieldBits-1:0] req_e0,
   input  logic signed [gtr_pkg::FieldBits-1:0] req_e1,
   input  logic signed [gtr_pkg::FieldBits-1:0] req_e2,
   input  logic signed [gtr_pkg::FieldBits-1:0] req_e3,
   output logic                                rsp_valid,
   output logic [gtr_pkg::OutRowBits-1:0]      rsp_out_row,
   output logic [gtr_pkg::ResultBits-1:0]      rsp_c0,
   output logic [gtr_pkg::ResultBits-1:0]      rsp_c1,
   output logic [gtr_pkg::ResultBits-1:0]      rsp_c2,
   output logic [gtr_pkg::ResultBits-1:0]      rsp_c3,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gtr_pkg::CsrAddrBits-1:0]     paddr,
   input  logic [gtr_pkg::CsrDataBits-1:0]     pwdata,
   output logic [gtr_pkg::CsrDataBits-1:0]     prdata,
   output logic                                pready
);

   localparam int AddrBits = (WEIGHT_ROWS > 1) ? $clog2(WEIGHT_ROWS) : 1;

   gtr_pkg::gtr_state_type                                    state_ff;
   gtr_pkg::gtr_state_type                                    state_in;
   gtr_pkg::gtr_lane_ctl_type                                 lane_ctl;
   logic [gtr_pkg::DepthBits-1:0]                             acc_depth_ff;
   logic [gtr_pkg::DepthBits-1:0]                             depth_eff;
   logic [gtr_pkg::DepthBits-1:0]                             step_ff;
   logic [gtr_pkg::DepthBits-1:0]                             step_in;
   logic [AddrBits-1:0]                                       widx_ff;
   logic [AddrBits-1:0]                                       widx_in;
   logic                                                      accept;
   logic                                                      act_accept;
   logic                                                      wr_en;
   logic                                                      tile_done;
   logic                                                      drain_go;
   logic                                                      drain_busy;
   logic                                                      csr_write;
   logic [gtr_pkg::FieldBits-1:0]                             req_elem [gtr_pkg::MaxLanes];
   logic [ROW_LANES-1:0][ELEM_BITS-1:0]                       act_ff;
   logic [COL_LANES-1:0][ELEM_BITS-1:0]                       wr_data;
   logic [COL_LANES-1:0][ELEM_BITS-1:0]                       wrd_ff;
   logic [COL_LANES-1:0][ELEM_BITS-1:0]                       wmem [WEIGHT_ROWS];
   logic [ROW_LANES-1:0][COL_LANES-1:0][gtr_pkg::AccBits-1:0] accs;
   logic [gtr_pkg::MaxLanes-1:0][gtr_pkg::ResultBits-1:0]     rsp_cols;

   assign req_elem[0] = req_e0;
   assign req_elem[1] = req_e1;
   assign req_elem[2] = req_e2;
   assign req_elem[3] = req_e3;

   assign accept     = start && !busy;
   assign act_accept = accept && (req_kind == gtr_pkg::KIND_ACT);
   assign wr_en      = accept && (req_kind == gtr_pkg::KIND_WEIGHT) &&
                       ({1'b0, req_row} < (gtr_pkg::RowBits + 1)'(WEIGHT_ROWS));

   for (genvar j = 0; j < COL_LANES; j++) begin : g_wdata
      assign wr_data[j] = req_elem[j][ELEM_BITS-1:0];
   end

   // Configuration register.
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = gtr_pkg::CsrDataBits'(acc_depth_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_depth_ff <= gtr_pkg::AccDepthReset;
      end else if (csr_write && (paddr[2] == gtr_pkg::CSR_ACC_DEPTH)) begin
         acc_depth_ff <= pwdata[gtr_pkg::DepthBits-1:0];
      end
   end

   // Weight memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[req_row[AddrBits-1:0]] <= wr_data;
      end
      if (act_accept) begin
         wrd_ff <= wmem[widx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (act_accept) begin
         for (int i = 0; i < ROW_LANES; i++) begin
            act_ff[i] <= req_elem[i][ELEM_BITS-1:0];
         end
      end
   end

   // Sequencer for one activation item.
   assign depth_eff = (acc_depth_ff == '0) ? gtr_pkg::DepthBits'(1) : acc_depth_ff;
   assign tile_done = ({1'b0, step_ff} + 1'b1) >= {1'b0, depth_eff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      widx_in  = widx_ff;
      drain_go = 1'b0;
      lane_ctl = '0;
      case (state_ff)
         gtr_pkg::S_IDLE: begin
            if (act_accept) begin
               state_in = gtr_pkg::S_MUL;
            end
         end
         gtr_pkg::S_MUL: begin
            lane_ctl.prod_en = 1'b1;
            state_in         = gtr_pkg::S_ACC;
         end
         gtr_pkg::S_ACC: begin
            lane_ctl.acc_en   = 1'b1;
            lane_ctl.acc_load = (step_ff == '0);
            state_in          = gtr_pkg::S_IDLE;
            if (tile_done) begin
               drain_go = 1'b1;
               step_in  = '0;
               widx_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
               widx_in = (widx_ff == AddrBits'(WEIGHT_ROWS - 1)) ? '0 : widx_ff + 1'b1;
            end
         end
         default: begin
            state_in = gtr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtr_pkg::S_IDLE;
         step_ff  <= '0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         widx_ff  <= widx_in;
      end
   end

   assign busy = (state_ff != gtr_pkg::S_IDLE) || drain_busy;

   for (genvar i = 0; i < ROW_LANES; i++) begin : g_lane
      gtr_lane #(
         .COL_LANES (COL_LANES),
         .ELEM_BITS (ELEM_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .act   (act_ff[i]),
         .wrow  (wrd_ff),
         .acc   (accs[i])
      );
   end

   gtr_drain #(
      .ROW_LANES (ROW_LANES),
      .COL_LANES (COL_LANES)
   ) u_drain (
      .clock       (clock),
      .reset       (reset),
      .go          (drain_go),
      .accs        (accs),
      .busy        (drain_busy),
      .rsp_valid   (rsp_valid),
      .rsp_out_row (rsp_out_row),
      .rsp_cols    (rsp_cols),
      .rsp_last    (rsp_last)
   );

   assign rsp_c0 = rsp_cols[0];
   assign rsp_c1 = rsp_cols[1];
   assign rsp_c2 = rsp_cols[2];
   assign rsp_c3 = rsp_cols[3];

   `GTR_ASSERT_NOW(a_last_row, clock, reset, rsp_valid && rsp_last,
      rsp_out_row == gtr_pkg::OutRowBits'(ROW_LANES - 1),
      "last flag on a row that is not the final one")
   `GTR_ASSERT_NEXT(a_rows_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid,
      "result rows of a tile are not back to back")
   `GTR_ASSERT_NEXT(a_done_holds_busy, clock, reset, state_ff == gtr_pkg::S_ACC && tile_done,
      busy, "tile completed without holding off new items")

endmodule
